// ----- hdl/cv3s_pkg.sv -----
package cv3s_pkg;

   // Default parameter values.
   localparam int KERNEL_DEF    = 3;
   localparam int MAX_WIDTH_DEF = 1024;

   // Field widths.
   localparam int WIN         = 3;   // window rows: the current row plus two line stores
   localparam int PIX_W       = 16;
   localparam int COEF_W      = 16;
   localparam int PROD_W      = 32;
   localparam int COLSUM_W    = 34;
   localparam int RES_W       = 40;
   localparam int BIAS_W      = 32;
   localparam int DIM_W       = 11;
   localparam int ROW_W       = 10;
   localparam int OUT_IDX_W   = 10;
   localparam int MAX_ROWS    = 1024;
   localparam int RST_DIM     = 28;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 3;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [WIN-1:0][PIX_W-1:0] column_type;

   // Control handed from the top level to every window cell.
   typedef struct packed {
      logic shift;     // a new column enters the window
      logic advance;   // the arithmetic stages move on
   } cell_ctl_type;

   // Position of one result as it travels down the pipeline.
   typedef struct packed {
      logic [OUT_IDX_W-1:0] row;
      logic [OUT_IDX_W-1:0] col;
      logic                 last;
   } meta_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_ROW0    = 3'd0,
      CSR_COEF_ROW1    = 3'd1,
      CSR_COEF_ROW2    = 3'd2,
      CSR_BIAS_VALUE   = 3'd3,
      CSR_IMAGE_WIDTH  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5
   } csr_index_type;

endpackage

// ----- hdl/cv3s_cell.sv -----
// One window column: holds three pixels, passes them to its left neighbor on
// each shift, and forms the weighted sum of its column over two stages.
module cv3s_cell (
   input  logic                              clock,
   input  cv3s_pkg::cell_ctl_type            ctl,
   input  cv3s_pkg::column_type              col_in,
   input  cv3s_pkg::column_type              coef_col,
   output cv3s_pkg::column_type              col_out,
   output logic signed [cv3s_pkg::COLSUM_W-1:0] col_sum
);

   cv3s_pkg::column_type                  col_ff;
   logic signed [cv3s_pkg::PROD_W-1:0]    prod_ff [cv3s_pkg::WIN];
   logic signed [cv3s_pkg::PROD_W-1:0]    prod_in [cv3s_pkg::WIN];
   logic signed [cv3s_pkg::COLSUM_W-1:0]  sum_ff;
   logic signed [cv3s_pkg::COLSUM_W-1:0]  sum_in;

   always_comb begin
      for (int i = 0; i < cv3s_pkg::WIN; i++) begin
         prod_in[i] = cv3s_pkg::PROD_W'($signed(col_ff[i])) *
                      cv3s_pkg::PROD_W'($signed(coef_col[i]));
      end
      sum_in = '0;
      for (int i = 0; i < cv3s_pkg::WIN; i++) begin
         sum_in = sum_in + cv3s_pkg::COLSUM_W'(prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         col_ff <= col_in;
      end
      if (ctl.advance) begin
         for (int i = 0; i < cv3s_pkg::WIN; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         sum_ff <= sum_in;
      end
   end

   assign col_out = col_ff;
   assign col_sum = sum_ff;

endmodule

// ----- hdl/cv3s_line_store.sv -----
// Two line stores holding the previous two rows. Each column is read when a
// request is taken and rewritten when that request moves on; a read that meets
// the write to the same column in the same cycle takes the written data instead.
module cv3s_line_store #(
   parameter int MAX_WIDTH = cv3s_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  cv3s_pkg::pix_type             wr_pix,
   output cv3s_pkg::pix_type             line1,
   output cv3s_pkg::pix_type             line2
);

   cv3s_pkg::pix_type line1_mem [MAX_WIDTH];
   cv3s_pkg::pix_type line2_mem [MAX_WIDTH];

   cv3s_pkg::pix_type rd1_ff;
   cv3s_pkg::pix_type rd2_ff;
   cv3s_pkg::pix_type fwd1_ff;
   cv3s_pkg::pix_type fwd2_ff;
   logic              fwd_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd1_ff  <= line1_mem[rd_addr];
         rd2_ff  <= line2_mem[rd_addr];
         fwd_ff  <= wr_en && (wr_addr == rd_addr);
         fwd1_ff <= wr_pix;
         fwd2_ff <= line1;
      end
      if (wr_en) begin
         line1_mem[wr_addr] <= wr_pix;
         line2_mem[wr_addr] <= line1;
      end
   end

   assign line1 = fwd_ff ? fwd1_ff : rd1_ff;
   assign line2 = fwd_ff ? fwd2_ff : rd2_ff;

endmodule

// ----- hdl/conv2d_valid_3x3_stream_top.sv -----
// Streaming 3x3 valid convolution over a raster-order pixel stream.
// Requests arrive on req_valid/req_ready, one Q8.8 pixel each, with
// req_frame_start marking the first pixel of an image. Results leave on
// rsp_valid/rsp_ready: bias plus the window sum in units of 2^-22, the output
// row and column, and rsp_frame_end on the last result of an image. Only
// pixels whose window lies fully inside the image give a result.
// One request is taken every cycle while the result channel flows. After its
// request is taken, a result passes through position and line store read,
// window shift, multiply, column sum, and the final add with the bias into
// the output register. Every stage moves together, so a stall on the result
// side holds the whole pipeline and drops req_ready until the held result
// is taken; nothing is lost or repeated. Kernel coefficients, bias and
// geometry come from the csr_ write port and are to be written by the user
// while the block is idle; the block does not enforce it. Width and height
// are clamped on write. Reset clears the pipeline and position counters and
// loads the register reset values (width and height 28). The line stores are
// not cleared: a column is always written before a result can depend on it.
module conv2d_valid_3x3_stream_top #(
   parameter int KERNEL    = cv3s_pkg::KERNEL_DEF,
   parameter int MAX_WIDTH = cv3s_pkg::MAX_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [cv3s_pkg::PIX_W-1:0]      req_pixel,
   input  logic                                   req_frame_start,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [cv3s_pkg::RES_W-1:0]      rsp_conv_value,
   output logic [cv3s_pkg::OUT_IDX_W-1:0]         rsp_out_row,
   output logic [cv3s_pkg::OUT_IDX_W-1:0]         rsp_out_col,
   output logic                                   rsp_frame_end,
   // configuration write port
   input  logic                                   csr_wr_en,
   input  logic [cv3s_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cv3s_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int EXW   = (WW > cv3s_pkg::DIM_W) ? WW : cv3s_pkg::DIM_W;
   localparam int OW    = (CW > cv3s_pkg::OUT_IDX_W) ? CW : cv3s_pkg::OUT_IDX_W;
   localparam int OFF   = cv3s_pkg::WIN - KERNEL;
   localparam int RST_W = (MAX_WIDTH < cv3s_pkg::RST_DIM) ? MAX_WIDTH : cv3s_pkg::RST_DIM;
   localparam int RW    = cv3s_pkg::ROW_W;

   // ---------------------------------------------------------------------
   // Configuration registers. Geometry is stored already clamped so the
   // position logic needs no clamping of its own.
   // ---------------------------------------------------------------------
   logic [cv3s_pkg::CSR_DATA_W-1:0]        coef_ff [cv3s_pkg::WIN];
   logic signed [cv3s_pkg::BIAS_W-1:0]     bias_ff;
   logic [WW-1:0]                          width_ff;
   logic [cv3s_pkg::DIM_W-1:0]             height_ff;
   logic [EXW-1:0]                         wr_width_ext;
   logic [WW-1:0]                          width_in;
   logic [cv3s_pkg::DIM_W-1:0]             wr_height;
   logic [cv3s_pkg::DIM_W-1:0]             height_in;

   always_comb begin
      wr_width_ext = EXW'(csr_wdata[cv3s_pkg::DIM_W-1:0]);
      if (wr_width_ext == '0) begin
         width_in = WW'(1);
      end else if (wr_width_ext > EXW'(MAX_WIDTH)) begin
         width_in = WW'(MAX_WIDTH);
      end else begin
         width_in = wr_width_ext[WW-1:0];
      end
      wr_height = csr_wdata[cv3s_pkg::DIM_W-1:0];
      if (wr_height == '0) begin
         height_in = cv3s_pkg::DIM_W'(1);
      end else if (wr_height > cv3s_pkg::DIM_W'(cv3s_pkg::MAX_ROWS)) begin
         height_in = cv3s_pkg::DIM_W'(cv3s_pkg::MAX_ROWS);
      end else begin
         height_in = wr_height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cv3s_pkg::WIN; i++) begin
            coef_ff[i] <= '0;
         end
         bias_ff   <= '0;
         width_ff  <= WW'(RST_W);
         height_ff <= cv3s_pkg::DIM_W'(cv3s_pkg::RST_DIM);
      end else if (csr_wr_en) begin
         case (csr_index)
            cv3s_pkg::CSR_COEF_ROW0:    coef_ff[0] <= csr_wdata;
            cv3s_pkg::CSR_COEF_ROW1:    coef_ff[1] <= csr_wdata;
            cv3s_pkg::CSR_COEF_ROW2:    coef_ff[2] <= csr_wdata;
            cv3s_pkg::CSR_BIAS_VALUE:   bias_ff <= $signed(csr_wdata[cv3s_pkg::BIAS_W-1:0]);
            cv3s_pkg::CSR_IMAGE_WIDTH:  width_ff <= width_in;
            cv3s_pkg::CSR_IMAGE_HEIGHT: height_ff <= height_in;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake. All stages advance together whenever the output register
   // is empty or being emptied.
   // ---------------------------------------------------------------------
   logic advance;
   logic accept;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && advance;
   assign req_ready = advance;

   // ---------------------------------------------------------------------
   // Position tracking. A frame start restarts at the origin; a column or
   // row at or past the current geometry wraps, which also covers a
   // geometry change in the middle of an image.
   // ---------------------------------------------------------------------
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   c0, c1;
   logic [RW-1:0]   r0, r2;
   logic [RW:0]     r1, r2_inc;
   logic            col_wrap;
   logic            emit;
   logic            last;
   logic [OW-1:0]   col_diff;
   logic [RW-1:0]   row_diff;

   always_comb begin
      c0       = req_frame_start ? '0 : col_ff;
      r0       = req_frame_start ? '0 : row_ff;
      col_wrap = WW'(c0) >= width_ff;
      c1       = col_wrap ? '0 : c0;
      r1       = {1'b0, r0} + (RW+1)'(col_wrap);
      r2       = (r1 >= height_ff) ? '0 : r1[RW-1:0];

      emit = (r2 >= RW'(KERNEL - 1)) && (c1 >= CW'(KERNEL - 1));
      last = ((RW+1)'(r2) == height_ff - 1'b1) && (WW'(c1) == width_ff - 1'b1);

      r2_inc = (RW+1)'(r2) + 1'b1;
      if (WW'(c1) + 1'b1 >= width_ff) begin
         col_in = '0;
         row_in = (r2_inc >= height_ff) ? '0 : r2_inc[RW-1:0];
      end else begin
         col_in = c1 + 1'b1;
         row_in = r2;
      end

      col_diff = OW'(c1) - OW'(KERNEL - 1);
      row_diff = r2 - RW'(KERNEL - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: the request with its position; line store data arrives.
   // ---------------------------------------------------------------------
   logic               a_valid_ff;
   logic               a_emit_ff;
   cv3s_pkg::pix_type  a_pix_ff;
   logic [CW-1:0]      a_col_ff;
   cv3s_pkg::meta_type a_meta_ff;
   logic               shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_emit_ff      <= emit;
         a_pix_ff       <= req_pixel;
         a_col_ff       <= c1;
         a_meta_ff.row  <= row_diff;
         a_meta_ff.col  <= col_diff[cv3s_pkg::OUT_IDX_W-1:0];
         a_meta_ff.last <= last;
      end
   end

   // The window shifts and the line stores are rewritten as stage A moves on.
   assign shift = advance && a_valid_ff;

   cv3s_pkg::pix_type line1;
   cv3s_pkg::pix_type line2;

   cv3s_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c1),
      .wr_en   (shift),
      .wr_addr (a_col_ff),
      .wr_pix  (a_pix_ff),
      .line1   (line1),
      .line2   (line2)
   );

   // ---------------------------------------------------------------------
   // Window: a chain of column cells. The newest column enters the right
   // end; rows are ordered oldest (two rows up) to newest.
   // ---------------------------------------------------------------------
   cv3s_pkg::column_type new_col;
   cv3s_pkg::column_type coef_col [cv3s_pkg::WIN];
   cv3s_pkg::column_type cell_out [1:cv3s_pkg::WIN-1];
   logic signed [cv3s_pkg::COLSUM_W-1:0] col_sum [cv3s_pkg::WIN];
   cv3s_pkg::cell_ctl_type cell_ctl;

   assign new_col[0] = line2;
   assign new_col[1] = line1;
   assign new_col[2] = a_pix_ff;

   assign cell_ctl.shift   = shift;
   assign cell_ctl.advance = advance;

   // A smaller kernel sits in the bottom right corner of the window; the
   // other taps get zero weight.
   always_comb begin
      for (int wj = 0; wj < cv3s_pkg::WIN; wj++) begin
         for (int wi = 0; wi < cv3s_pkg::WIN; wi++) begin
            if (wi >= OFF && wj >= OFF) begin
               coef_col[wj][wi] = coef_ff[wi - OFF][cv3s_pkg::COEF_W * (wj - OFF) +:
                                                    cv3s_pkg::COEF_W];
            end else begin
               coef_col[wj][wi] = '0;
            end
         end
      end
   end

   for (genvar k = 0; k < cv3s_pkg::WIN; k++) begin : g_cell
      if (k == cv3s_pkg::WIN - 1 && k == 0) begin : g_only
         cv3s_cell u_cell (
            .clock    (clock),
            .ctl      (cell_ctl),
            .col_in   (new_col),
            .coef_col (coef_col[k]),
            .col_out  (),
            .col_sum  (col_sum[k])
         );
      end else if (k == cv3s_pkg::WIN - 1) begin : g_right
         cv3s_cell u_cell (
            .clock    (clock),
            .ctl      (cell_ctl),
            .col_in   (new_col),
            .coef_col (coef_col[k]),
            .col_out  (cell_out[k]),
            .col_sum  (col_sum[k])
         );
      end else if (k == 0) begin : g_left
         cv3s_cell u_cell (
            .clock    (clock),
            .ctl      (cell_ctl),
            .col_in   (cell_out[k+1]),
            .coef_col (coef_col[k]),
            .col_out  (),
            .col_sum  (col_sum[k])
         );
      end else begin : g_mid
         cv3s_cell u_cell (
            .clock    (clock),
            .ctl      (cell_ctl),
            .col_in   (cell_out[k+1]),
            .coef_col (coef_col[k]),
            .col_out  (cell_out[k]),
            .col_sum  (col_sum[k])
         );
      end
   end

   // ---------------------------------------------------------------------
   // Stages B, C, D follow the window, products and column sums. Only
   // requests whose window lies inside the image travel on as valid.
   // ---------------------------------------------------------------------
   logic               b_valid_ff, c_valid_ff, d_valid_ff;
   cv3s_pkg::meta_type b_meta_ff, c_meta_ff, d_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff   <= a_valid_ff && a_emit_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output register: bias plus the three column sums.
   // ---------------------------------------------------------------------
   logic signed [cv3s_pkg::RES_W-1:0] conv_in;
   logic signed [cv3s_pkg::RES_W-1:0] conv_ff;
   cv3s_pkg::meta_type                rsp_meta_ff;

   always_comb begin
      conv_in = cv3s_pkg::RES_W'(bias_ff);
      for (int k = 0; k < cv3s_pkg::WIN; k++) begin
         conv_in = conv_in + cv3s_pkg::RES_W'(col_sum[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_meta_ff   <= a_meta_ff;
         c_meta_ff   <= b_meta_ff;
         d_meta_ff   <= c_meta_ff;
         rsp_meta_ff <= d_meta_ff;
         conv_ff     <= conv_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_conv_value = conv_ff;
   assign rsp_out_row    = rsp_meta_ff.row;
   assign rsp_out_col    = rsp_meta_ff.col;
   assign rsp_frame_end  = rsp_meta_ff.last;

endmodule
